// ----- rtl/core/chl_pkg.sv -----
// ----------------------------------------------------------------------------
// chl_pkg
// Shared widths, codes and structs of the length-limited canonical Huffman block.
// ----------------------------------------------------------------------------
`default_nettype none
package chl_pkg;
	localparam int MAX_SYMBOLS    = 512;
	localparam int MAX_CODE_BITS  = 32;
	localparam int MAX_RAW_LENGTH = 63;
	localparam int SYM_W  = $clog2(MAX_SYMBOLS);
	localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
	localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
	localparam int RAW_W  = $clog2(MAX_RAW_LENGTH + 1);
	localparam int HIST_D = MAX_RAW_LENGTH + 1;
	localparam int LIM_AW = $clog2(MAX_CODE_BITS);
	localparam int CODE_W = 32;
	localparam int CTAB_W = LEN_W + CODE_W;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INFEASIBLE = 2'd1;
	localparam logic [1:0] ST_REJECTED   = 2'd2;
	localparam logic [1:0] ST_NOT_BUILT  = 2'd3;

	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_SYMBOLS = 1'b1;

	typedef struct packed {
		logic [SYM_W-1:0]  raw_addr;
		logic              code_we;
		logic [SYM_W-1:0]  code_addr;
		logic [CTAB_W-1:0] code_wdata;
	} chl_mem_t;

	typedef struct packed {
		logic done;
		logic ok;
	} chl_done_t;
endpackage
`default_nettype wire

// ----- rtl/core/chl_if.sv -----
// ----------------------------------------------------------------------------
// chl_in_if / chl_out_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface chl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [8:0] symbol_index;
	logic [7:0] raw_length;
	modport source (output valid, func, symbol_index, raw_length, input ready);
	modport sink (input valid, func, symbol_index, raw_length, output ready);
endinterface

interface chl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  code_length;
	logic [31:0] code_bits;
	modport source (output valid, status, code_length, code_bits, input ready);
	modport sink (input valid, status, code_length, code_bits, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/canonical_huffman_length_limited.sv -----
// ----------------------------------------------------------------------------
// canonical_huffman_length_limited
// Length table, command decode and result register around the build sequencer.
// ----------------------------------------------------------------------------
// channel  dir  fields
// in_ch    in   func, symbol_index, raw_length
// out_ch   out  status, code_length, code_bits
// cfg      in   cfg_we, cfg_index, cfg_data
//
// Load and unused commands, and reads before a build, are answered directly; a read
// of a built table goes through the code table read port. Build: clears the 32
// count entries, scans every symbol, rebalances, hands out lengths once per raw length
// in use, then runs one code pass over all 512 entries and one over n for each other length up to lim.
// After reset all 512 entries of the length table are cleared; no item is taken then.
// An item is taken only while the result register is empty or being drained.
`default_nettype none
module canonical_huffman_length_limited (
	input  wire logic clk,
	input  wire logic arst_n,
	chl_in_if.sink    in_ch,
	chl_out_if.source out_ch,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [9:0] cfg_data
);
	import chl_pkg::*;

	localparam logic [1:0] T_CLEAR = 2'd0;
	localparam logic [1:0] T_IDLE  = 2'd1;
	localparam logic [1:0] T_READ  = 2'd2;
	localparam logic [1:0] T_BUILD = 2'd3;

	logic [1:0]        st_q;
	logic [SYM_W-1:0]  clr_q;
	logic              built_q;
	logic [5:0]        max_len_q;
	logic [9:0]        symbols_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [LEN_W-1:0]  length_q;
	logic [CODE_W-1:0] bits_q;

	logic              take;
	logic              out_set;
	logic              bld_start;
	logic [LEN_W-1:0]  lim;
	logic [CNT_W-1:0]  n;
	chl_mem_t          bmem;
	chl_done_t         fin;
	logic              raw_we;
	logic [SYM_W-1:0]  raw_addr;
	logic [RAW_W-1:0]  raw_wdata;
	logic [RAW_W-1:0]  raw_rdata;
	logic              code_we;
	logic [SYM_W-1:0]  code_addr;
	logic [CTAB_W-1:0] code_rdata;
	logic              rejected;

	assign in_ch.ready = (st_q == T_IDLE) && (!out_valid_q || out_ch.ready);
	assign take        = in_ch.valid && in_ch.ready;
	assign rejected    = in_ch.raw_length > 8'(MAX_RAW_LENGTH);
	assign bld_start   = take && in_ch.func == FUNC_BUILD;

	// result ready now: immediate answers, finished read, finished build
	assign out_set = (take && in_ch.func != FUNC_BUILD && !(in_ch.func == FUNC_READ && built_q))
		|| st_q == T_READ || (st_q == T_BUILD && fin.done);

	assign lim = (max_len_q == '0) ? LEN_W'(1)
		: (max_len_q > 6'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : LEN_W'(max_len_q);
	assign n = (symbols_q > 10'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : CNT_W'(symbols_q);

	always_comb begin
		raw_we    = 1'b0;
		raw_addr  = in_ch.symbol_index;
		raw_wdata = RAW_W'(in_ch.raw_length);
		code_we   = 1'b0;
		code_addr = in_ch.symbol_index;
		unique case (st_q)
			T_CLEAR: begin
				raw_we    = 1'b1;
				raw_addr  = clr_q;
				raw_wdata = '0;
			end
			T_BUILD: begin
				raw_addr  = bmem.raw_addr;
				code_we   = bmem.code_we;
				code_addr = bmem.code_addr;
			end
			default: begin
				raw_we = take && in_ch.func == FUNC_LOAD && !rejected;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 6'd15;
			symbols_q <= 10'd286;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_LEN: max_len_q <= cfg_data[5:0];
				REG_SYMBOLS: symbols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_CLEAR;
			clr_q       <= '0;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && !out_ch.ready);
			unique case (st_q)
				T_CLEAR: begin
					clr_q <= clr_q + SYM_W'(1);
					if (clr_q == '1) begin
						st_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (take) begin
						length_q <= '0;
						bits_q   <= '0;
						unique case (in_ch.func)
							FUNC_LOAD: status_q <= rejected ? ST_REJECTED : ST_OK;
							FUNC_BUILD: begin
								status_q <= ST_OK;
								st_q     <= T_BUILD;
							end
							FUNC_READ: begin
								status_q <= built_q ? ST_OK : ST_NOT_BUILT;
								if (built_q) begin
									st_q <= T_READ;
								end
							end
							default: status_q <= ST_OK;
						endcase
					end
				end
				T_READ: begin
					length_q <= code_rdata[CTAB_W-1:CODE_W];
					bits_q   <= code_rdata[CODE_W-1:0];
					st_q     <= T_IDLE;
				end
				T_BUILD: begin
					if (fin.done) begin
						status_q <= fin.ok ? ST_OK : ST_INFEASIBLE;
						built_q  <= fin.ok;
						st_q     <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.code_length = length_q;
	assign out_ch.code_bits   = bits_q;

	chl_ram #(.WIDTH(RAW_W), .DEPTH(MAX_SYMBOLS)) u_raw_ram (
		.clk   (clk),
		.we    (raw_we),
		.addr  (raw_addr),
		.wdata (raw_wdata),
		.rdata (raw_rdata)
	);

	chl_ram #(.WIDTH(CTAB_W), .DEPTH(MAX_SYMBOLS)) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.addr  (code_addr),
		.wdata (bmem.code_wdata),
		.rdata (code_rdata)
	);

	chl_builder u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (bld_start),
		.lim       (lim),
		.n         (n),
		.raw_rdata (raw_rdata),
		.mem       (bmem),
		.fin       (fin)
	);

`ifndef SYNTH
	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == T_CLEAR |-> !in_ch.ready)
		else $error("item taken during table clear");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> length_q == '0 && bits_q == '0)
		else $error("error result carries code data");

	a_fin_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		fin.done |-> st_q == T_BUILD)
		else $error("build finished outside build");

	a_build_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == T_BUILD && fin.done |=> out_valid_q && built_q == (status_q == ST_OK))
		else $error("build result mismatch");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/chl_ram.sv -----
// ----------------------------------------------------------------------------
// chl_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module chl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/core/chl_builder.sv -----
// ----------------------------------------------------------------------------
// chl_builder
// Build sequencer: count, rebalance, hand out lengths, assign canonical codes.
// ----------------------------------------------------------------------------
`default_nettype none
module chl_builder (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [chl_pkg::LEN_W-1:0] lim,
	input  wire logic [chl_pkg::CNT_W-1:0] n,
	input  wire logic [chl_pkg::RAW_W-1:0] raw_rdata,
	output chl_pkg::chl_mem_t              mem,
	output chl_pkg::chl_done_t             fin
);
	import chl_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_SC_A = 4'd2;
	localparam logic [3:0] S_SC_B = 4'd3;
	localparam logic [3:0] S_SC_C = 4'd4;
	localparam logic [3:0] S_RB_A = 4'd5;
	localparam logic [3:0] S_RB_B = 4'd6;
	localparam logic [3:0] S_RB_C = 4'd7;
	localparam logic [3:0] S_RB_D = 4'd8;
	localparam logic [3:0] S_AS_L = 4'd9;
	localparam logic [3:0] S_AS_A = 4'd10;
	localparam logic [3:0] S_AS_B = 4'd11;
	localparam logic [3:0] S_AS_J = 4'd12;
	localparam logic [3:0] S_AS_K = 4'd13;
	localparam logic [3:0] S_CN_A = 4'd14;
	localparam logic [3:0] S_CN_B = 4'd15;

	localparam logic [CNT_W-1:0] SYM_END = CNT_W'(MAX_SYMBOLS);
	localparam logic [RAW_W:0]   LEN_END = (RAW_W+1)'(HIST_D);

	logic [3:0]        st_q;
	logic [LEN_W-1:0]  lim_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  top_q;
	logic [CNT_W-1:0]  ovf_q;
	logic [LEN_W-1:0]  k_q;
	logic [LEN_W-1:0]  j_q;
	logic [RAW_W:0]    len_q;
	logic [LIM_AW-1:0] idx_q;
	logic [HIST_D-1:0] flag_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0]  prev_q;
	chl_done_t         fin_q;

	logic              cnt_we;
	logic [LIM_AW-1:0] cnt_addr;
	logic [CNT_W-1:0]  cnt_rdata;
	logic [CNT_W-1:0]  cnt_delta;
	logic [CNT_W-1:0]  cnt_wdata;
	logic              cnt_clr;
	logic              nl_we;
	logic [LEN_W-1:0]  nl_wdata;
	logic [LEN_W-1:0]  nl_rdata;

	logic [LEN_W-1:0]  lim_m1;
	logic [LEN_W-1:0]  len6;
	logic [LEN_W-1:0]  shamt;
	logic [CODE_W-1:0] code_cur;
	logic [LEN_W-1:0]  eff_len;
	logic [CNT_W-1:0]  cn_end;

	assign lim_m1 = lim_q - LEN_W'(1);
	assign len6   = len_q[LEN_W-1:0];
	assign shamt  = len6 - prev_q;
	assign code_cur = (prev_q < len6) ? (shamt[LEN_W-1] ? '0 : code_q << shamt[LEN_W-2:0])
		: code_q;
	assign eff_len = (i_q < n_q && raw_rdata != '0) ? nl_rdata : '0;
	assign cn_end  = (len_q == (RAW_W+1)'(1)) ? SYM_END : n_q;

	// shared count adder
	assign cnt_wdata = cnt_clr ? '0 : cnt_rdata + cnt_delta;

	always_comb begin
		cnt_we    = 1'b0;
		cnt_clr   = 1'b0;
		cnt_addr  = j_q[LIM_AW-1:0];
		cnt_delta = '0;
		nl_we     = 1'b0;
		nl_wdata  = j_q + LEN_W'(1);
		mem.raw_addr   = i_q[SYM_W-1:0];
		mem.code_we    = 1'b0;
		mem.code_addr  = i_q[SYM_W-1:0];
		mem.code_wdata = '0;
		unique case (st_q)
			S_CLR: begin
				cnt_we   = 1'b1;
				cnt_clr  = 1'b1;
				cnt_addr = i_q[LIM_AW-1:0];
			end
			S_SC_B: begin
				cnt_addr = LIM_AW'(raw_rdata - RAW_W'(1));
			end
			S_SC_C: begin
				cnt_we    = 1'b1;
				cnt_addr  = idx_q;
				cnt_delta = CNT_W'(1);
			end
			S_RB_A: begin
				cnt_addr = LIM_AW'(k_q - LEN_W'(1));
			end
			S_RB_B: begin
				cnt_addr  = LIM_AW'(k_q - LEN_W'(1));
				cnt_we    = (cnt_rdata != '0);
				cnt_delta = '1;
			end
			S_RB_C: begin
				cnt_addr = k_q[LIM_AW-1:0];
			end
			S_RB_D: begin
				cnt_we    = 1'b1;
				cnt_addr  = k_q[LIM_AW-1:0];
				cnt_delta = CNT_W'(2);
			end
			S_AS_J: begin
				if (j_q >= lim_q) begin
					nl_we    = 1'b1;
					nl_wdata = len6;
				end else if (j_q == lim_m1) begin
					nl_we = (top_q != '0);
				end
			end
			S_AS_K: begin
				cnt_we    = (cnt_rdata != '0);
				nl_we     = (cnt_rdata != '0);
				cnt_delta = '1;
			end
			S_CN_B: begin
				if (eff_len == len6) begin
					mem.code_we    = 1'b1;
					mem.code_wdata = {len6, code_cur};
				end else if (len_q == (RAW_W+1)'(1)) begin
					mem.code_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			fin_q  <= '0;
			flag_q <= '0;
		end else begin
			fin_q <= '0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						lim_q  <= lim;
						n_q    <= n;
						i_q    <= '0;
						top_q  <= '0;
						ovf_q  <= '0;
						flag_q <= '0;
						st_q   <= S_CLR;
					end
				end
				S_CLR: begin
					if (i_q[LIM_AW-1:0] == '1) begin
						i_q  <= '0;
						st_q <= S_SC_A;
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				S_SC_A: begin
					if (i_q == n_q) begin
						k_q  <= lim_m1;
						st_q <= S_RB_A;
					end else begin
						st_q <= S_SC_B;
					end
				end
				S_SC_B: begin
					flag_q[raw_rdata] <= 1'b1;
					if (raw_rdata == '0) begin
						i_q  <= i_q + CNT_W'(1);
						st_q <= S_SC_A;
					end else if (LEN_W'(raw_rdata) >= lim_q || raw_rdata > RAW_W'(MAX_CODE_BITS))
					begin
						top_q <= top_q + CNT_W'(1);
						if (LEN_W'(raw_rdata) > lim_q || raw_rdata > RAW_W'(MAX_CODE_BITS)) begin
							ovf_q <= ovf_q + CNT_W'(1);
						end
						i_q  <= i_q + CNT_W'(1);
						st_q <= S_SC_A;
					end else begin
						idx_q <= LIM_AW'(raw_rdata - RAW_W'(1));
						st_q  <= S_SC_C;
					end
				end
				S_SC_C: begin
					i_q  <= i_q + CNT_W'(1);
					st_q <= S_SC_A;
				end
				S_RB_A: begin
					if (ovf_q == '0) begin
						len_q <= (RAW_W+1)'(1);
						j_q   <= '0;
						st_q  <= S_AS_L;
					end else if (k_q == '0) begin
						fin_q <= '{done: 1'b1, ok: 1'b0};
						st_q  <= S_IDLE;
					end else begin
						st_q <= S_RB_B;
					end
				end
				S_RB_B: begin
					if (cnt_rdata == '0) begin
						k_q  <= k_q - LEN_W'(1);
						st_q <= S_RB_A;
					end else if (k_q == lim_m1) begin
						top_q <= top_q + CNT_W'(1);
						ovf_q <= ovf_q - CNT_W'(1);
						st_q  <= S_RB_A;
					end else begin
						top_q <= top_q - CNT_W'(1);
						st_q  <= S_RB_C;
					end
				end
				S_RB_C: begin
					st_q <= S_RB_D;
				end
				S_RB_D: begin
					k_q   <= k_q + LEN_W'(1);
					ovf_q <= ovf_q - CNT_W'(1);
					st_q  <= S_RB_A;
				end
				S_AS_L: begin
					if (len_q == LEN_END) begin
						len_q  <= (RAW_W+1)'(1);
						i_q    <= '0;
						code_q <= '0;
						prev_q <= '0;
						st_q   <= S_CN_A;
					end else if (!flag_q[len_q[RAW_W-1:0]]) begin
						len_q <= len_q + (RAW_W+1)'(1);
					end else begin
						i_q  <= '0;
						st_q <= S_AS_A;
					end
				end
				S_AS_A: begin
					if (i_q == n_q) begin
						len_q <= len_q + (RAW_W+1)'(1);
						st_q  <= S_AS_L;
					end else begin
						st_q <= S_AS_B;
					end
				end
				S_AS_B: begin
					if (raw_rdata != len_q[RAW_W-1:0]) begin
						i_q  <= i_q + CNT_W'(1);
						st_q <= S_AS_A;
					end else begin
						st_q <= S_AS_J;
					end
				end
				S_AS_J: begin
					if (j_q >= lim_q) begin
						i_q  <= i_q + CNT_W'(1);
						st_q <= S_AS_A;
					end else if (j_q == lim_m1) begin
						if (top_q == '0) begin
							j_q <= j_q + LEN_W'(1);
						end else begin
							top_q <= top_q - CNT_W'(1);
							i_q   <= i_q + CNT_W'(1);
							st_q  <= S_AS_A;
						end
					end else begin
						st_q <= S_AS_K;
					end
				end
				S_AS_K: begin
					if (cnt_rdata == '0) begin
						j_q <= j_q + LEN_W'(1);
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
					st_q <= (cnt_rdata == '0) ? S_AS_J : S_AS_A;
				end
				S_CN_A: begin
					if (i_q == cn_end) begin
						if (len6 >= lim_q) begin
							fin_q <= '{done: 1'b1, ok: 1'b1};
							st_q  <= S_IDLE;
						end else begin
							len_q <= len_q + (RAW_W+1)'(1);
							i_q   <= '0;
						end
					end else begin
						st_q <= S_CN_B;
					end
				end
				S_CN_B: begin
					if (eff_len == len6) begin
						code_q <= code_cur + CODE_W'(1);
						prev_q <= len6;
					end
					i_q  <= i_q + CNT_W'(1);
					st_q <= S_CN_A;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign fin = fin_q;

	chl_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CODE_BITS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	chl_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SYMBOLS)) u_len_ram (
		.clk   (clk),
		.we    (nl_we),
		.addr  (i_q[SYM_W-1:0]),
		.wdata (nl_wdata),
		.rdata (nl_rdata)
	);
endmodule
`default_nettype wire
